### sv/tgarle_pkg.sv
// Package for the TGA run-length pixel decoder.
// Shared types, register indexes and sizing constants; no dependencies.
package tgarle_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 31;
  localparam int QUEUE_DEPTH         = 4;
  localparam int CFG_INDEX_W         = 2;
  localparam int CFG_DATA_W          = 31;
  localparam int OUT_DATA_W          = 40;

  localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RLE_MODE        = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_COUNT     = 2'd2;

  localparam logic [2:0] BPP_FOUR    = 3'd4;
  localparam logic [2:0] SIZE_THREE  = 3'd3;
  localparam logic [2:0] SIZE_FOUR   = 3'd4;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] RUN_BIAS     = 8'd127;

  typedef enum logic [1:0] {
    PHASE_HEADER  = 2'd0,
    PHASE_LITERAL = 2'd1,
    PHASE_RUN     = 2'd2
  } phase_t;

  // One completed pixel handed from the parser to the color stage.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] cur;
    logic       four;
    logic [7:0] rep;
    logic       last;
  } pix_rec_t;

endpackage

### sv/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder.
// Instantiates tgarle_front, tgarle_queue and tgarle_back; uses tgarle_pkg.
//
// Usage:
//   s_* carries the pixel-data section of a TGA image, one byte per word.
//   m_* carries one decoded pixel per word: red, green, blue, alpha and a
//   repeat count, with tlast on the pixel that completes the image.
//   cfg_* writes bytes_per_pixel (index 0), rle_mode (1), pixel_count (2);
//   write only while no pixel is in flight.
// Throughput: one input byte per cycle while s_tready is high; a header byte or a
//   pixel byte that does not complete a pixel gives no output word.
// Path: the byte that completes a pixel goes through the parser into the
//   pixel queue, then into the alpha multiplier register, then through the
//   rounding divide into the output register.
// Reset: rst clears packet state, the queue and both output stages, and
//   loads bytes_per_pixel 4, rle_mode 1, pixel_count 1.
// Stall: when m_tready is low the output word holds, the multiply stage and
//   the four-entry pixel queue fill, and then s_tready drops.
module tga_rle_pixel_decoder #(
  parameter int COUNT_WIDTH = tgarle_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tgarle_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tgarle_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,  // data_byte[7:0]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // red[7:0], green[15:8], blue[23:16], alpha[31:24], repeat_count[39:32]
  output logic [tgarle_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                               m_tlast   // last_pixel
);

  logic                 push;
  logic                 pop;
  logic                 queue_full;
  logic                 queue_empty;
  tgarle_pkg::pix_rec_t push_rec;
  tgarle_pkg::pix_rec_t pop_rec;

  assign cfg_ready = 1'b1;

  tgarle_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_byte   (s_tdata),
    .queue_full(queue_full),
    .in_ready  (s_tready),
    .push      (push),
    .push_rec  (push_rec)
  );

  tgarle_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_rec(push_rec),
    .pop     (pop),
    .full    (queue_full),
    .empty   (queue_empty),
    .pop_rec (pop_rec)
  );

  tgarle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .queue_empty(queue_empty),
    .pop_rec    (pop_rec),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

### sv/tgarle_front.sv
// Byte parser for the TGA run-length pixel decoder: holds the configuration
// registers, tracks packets and pixel assembly, and pushes completed pixels.
// Depends on tgarle_pkg.
module tgarle_front #(
  parameter int COUNT_WIDTH = tgarle_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [tgarle_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tgarle_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                               in_valid,
  input  logic [7:0]                         in_byte,
  input  logic                               queue_full,
  output logic                               in_ready,
  output logic                               push,
  output tgarle_pkg::pix_rec_t               push_rec
);

  logic [2:0]                        bytes_per_pixel;
  logic                              rle_mode;
  logic [tgarle_pkg::CFG_DATA_W-1:0] pixel_count;

  tgarle_pkg::phase_t packet_phase, packet_phase_next;
  logic [7:0]             packet_pixels_left, packet_pixels_left_next;
  logic [1:0]             byte_in_pixel, byte_in_pixel_next;
  logic [23:0]            partial_pixel, partial_pixel_next;
  logic [COUNT_WIDTH-1:0] pixels_left, pixels_left_next;

  logic                   accept;
  logic                   four;
  logic [2:0]             size;
  logic [COUNT_WIDTH-1:0] pc_w;
  logic [COUNT_WIDTH-1:0] pl_eff;
  logic [7:0]             rep;
  logic                   complete;
  logic                   last;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign four     = (bytes_per_pixel == tgarle_pkg::BPP_FOUR);
  assign size     = four ? tgarle_pkg::SIZE_FOUR : tgarle_pkg::SIZE_THREE;
  assign pc_w     = COUNT_WIDTH'(pixel_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= tgarle_pkg::BPP_FOUR;
      rle_mode        <= 1'b1;
      pixel_count     <= tgarle_pkg::CFG_DATA_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tgarle_pkg::REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[2:0];
        tgarle_pkg::REG_RLE_MODE:        rle_mode        <= cfg_data[0];
        tgarle_pkg::REG_PIXEL_COUNT:     pixel_count     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    packet_phase_next       = packet_phase;
    packet_pixels_left_next = packet_pixels_left;
    byte_in_pixel_next      = byte_in_pixel;
    partial_pixel_next      = partial_pixel;
    rep                     = 8'd1;
    complete                = 1'b0;
    last                    = 1'b0;

    if (pixels_left == '0) begin
      pl_eff = (pc_w == '0) ? COUNT_WIDTH'(1) : pc_w;
    end else begin
      pl_eff = pixels_left;
    end
    pixels_left_next = pl_eff;

    if (rle_mode && packet_phase != tgarle_pkg::PHASE_LITERAL
        && packet_phase != tgarle_pkg::PHASE_RUN) begin
      if (in_byte[7]) begin
        packet_phase_next       = tgarle_pkg::PHASE_RUN;
        packet_pixels_left_next = in_byte - tgarle_pkg::RUN_BIAS;
      end else begin
        packet_phase_next       = tgarle_pkg::PHASE_LITERAL;
        packet_pixels_left_next = in_byte + 8'd1;
      end
      byte_in_pixel_next = 2'd0;
    end else if ({1'b0, byte_in_pixel} + 3'd1 < size) begin
      unique case (byte_in_pixel)
        2'd0: partial_pixel_next[7:0]   = in_byte;
        2'd1: partial_pixel_next[15:8]  = in_byte;
        2'd2: partial_pixel_next[23:16] = in_byte;
        2'd3: ;
      endcase
      byte_in_pixel_next = byte_in_pixel + 2'd1;
    end else begin
      complete           = 1'b1;
      byte_in_pixel_next = 2'd0;
      if (rle_mode) begin
        if (packet_phase == tgarle_pkg::PHASE_RUN) begin
          rep = (packet_pixels_left == 8'd0) ? 8'd1 : packet_pixels_left;
          if (COUNT_WIDTH'(rep) > pl_eff) begin
            rep = pl_eff[7:0];
          end
          packet_pixels_left_next = 8'd0;
          packet_phase_next       = tgarle_pkg::PHASE_HEADER;
        end else begin
          packet_pixels_left_next = packet_pixels_left - 8'd1;
          if (packet_pixels_left_next == 8'd0) begin
            packet_phase_next = tgarle_pkg::PHASE_HEADER;
          end
        end
      end
      pixels_left_next = pl_eff - COUNT_WIDTH'(rep);
      last             = (pixels_left_next == '0);
      if (last) begin
        packet_phase_next       = tgarle_pkg::PHASE_HEADER;
        packet_pixels_left_next = 8'd0;
        byte_in_pixel_next      = 2'd0;
        partial_pixel_next      = 24'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_phase       <= tgarle_pkg::PHASE_HEADER;
      packet_pixels_left <= 8'd0;
      byte_in_pixel      <= 2'd0;
      partial_pixel      <= 24'd0;
      pixels_left        <= '0;
    end else if (accept) begin
      packet_phase       <= packet_phase_next;
      packet_pixels_left <= packet_pixels_left_next;
      byte_in_pixel      <= byte_in_pixel_next;
      partial_pixel      <= partial_pixel_next;
      pixels_left        <= pixels_left_next;
    end
  end

  assign push           = accept && complete;
  assign push_rec.byte0 = partial_pixel[7:0];
  assign push_rec.byte1 = partial_pixel[15:8];
  assign push_rec.byte2 = partial_pixel[23:16];
  assign push_rec.cur   = in_byte;
  assign push_rec.four  = four;
  assign push_rec.rep   = rep;
  assign push_rec.last  = last;

endmodule

### sv/tgarle_queue.sv
// Short pixel queue between the byte parser and the color stage.
// Depends on tgarle_pkg.
module tgarle_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tgarle_pkg::pix_rec_t push_rec,
  input  logic                 pop,
  output logic                 full,
  output logic                 empty,
  output tgarle_pkg::pix_rec_t pop_rec
);

  localparam int PTR_W = $clog2(tgarle_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(tgarle_pkg::QUEUE_DEPTH + 1);

  tgarle_pkg::pix_rec_t entries [tgarle_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(tgarle_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### sv/tgarle_back.sv
// Color stage of the TGA run-length pixel decoder: swaps red and blue,
// premultiplies by alpha over two registered steps, holds the output word.
// Depends on tgarle_pkg.
module tgarle_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              queue_empty,
  input  tgarle_pkg::pix_rec_t              pop_rec,
  output logic                              pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tgarle_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                              m_tlast
);

  logic        advance;
  logic        s1_valid;
  logic [15:0] s1_prod_r;
  logic [15:0] s1_prod_g;
  logic [15:0] s1_prod_b;
  logic [7:0]  s1_alpha;
  logic [7:0]  s1_rep;
  logic        s1_last;

  logic [7:0]  src_r;
  logic [7:0]  mul_k;

  function automatic logic [7:0] div255_round(input logic [15:0] p);
    logic [16:0] x;
    logic [16:0] q;
    begin
      x = {1'b0, p} + 17'd127;
      q = (x + 17'd1 + (x >> 8)) >> 8;
      div255_round = q[7:0];
    end
  endfunction

  assign advance = !m_tvalid || m_tready;
  assign pop     = advance && !queue_empty;
  assign src_r   = pop_rec.four ? pop_rec.byte2 : pop_rec.cur;
  assign mul_k   = pop_rec.four ? pop_rec.cur : tgarle_pkg::ALPHA_OPAQUE;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= !queue_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_prod_r <= 16'(src_r) * 16'(mul_k);
      s1_prod_g <= 16'(pop_rec.byte1) * 16'(mul_k);
      s1_prod_b <= 16'(pop_rec.byte0) * 16'(mul_k);
      s1_alpha  <= mul_k;
      s1_rep    <= pop_rec.rep;
      s1_last   <= pop_rec.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {s1_rep, s1_alpha, div255_round(s1_prod_b),
                  div255_round(s1_prod_g), div255_round(s1_prod_r)};
      m_tlast <= s1_last;
    end
  end

endmodule
